// ----- hdl/frame_bump_allocator_core_assert.svh -----
// Assertion macros used by the frame bump allocator core
`ifndef FRAME_BUMP_ALLOCATOR_CORE_ASSERT_SVH
`define FRAME_BUMP_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define FBA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication
`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- hdl/fba_pkg.sv -----
// Types and constants of the frame bump allocator
`timescale 1ns / 1ps
package fba_pkg;

   localparam int FIELD_BITS = 24;
   localparam int INDEX_BITS = 2;

   typedef enum logic {
      CMD_ALLOC     = 1'b0,
      CMD_FRAME_END = 1'b1
   } command_type;

endpackage

// ----- hdl/fba_cell.sv -----
// One history cell: holds a frame usage and passes it on along the ring
`timescale 1ns / 1ps
module fba_cell #(
   parameter int SIZE_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  logic [SIZE_BITS-1:0] data_in,
   output logic [SIZE_BITS-1:0] data_out
);

   logic [SIZE_BITS-1:0] value_ff;
   logic [SIZE_BITS-1:0] value_in;

   always_comb begin
      value_in = shift_en ? data_in : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign data_out = value_ff;

endmodule

// ----- hdl/fba_ring.sv -----
// History ring of cells with a rotating peak search
`timescale 1ns / 1ps
module fba_ring #(
   parameter int HISTORY_COUNT = 16,
   parameter int SIZE_BITS     = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [SIZE_BITS-1:0] load_value,
   output logic                 done,
   output logic [SIZE_BITS-1:0] peak
);

   localparam int CNT_W = (HISTORY_COUNT > 1) ? $clog2(HISTORY_COUNT) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HISTORY_COUNT - 1);

   logic [SIZE_BITS-1:0] tap [HISTORY_COUNT];
   logic [SIZE_BITS-1:0] head_in;
   logic                 shift_en;

   logic                 run_ff,  run_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff,  cnt_in;
   logic [SIZE_BITS-1:0] peak_ff, peak_in;

   assign head_in  = load ? load_value : tap[HISTORY_COUNT-1];
   assign shift_en = load | run_ff;

   fba_cell #(.SIZE_BITS(SIZE_BITS)) u_cell_head (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .data_in  (head_in),
      .data_out (tap[0])
   );

   generate
      for (genvar i = 1; i < HISTORY_COUNT; i++) begin : g_cell
         fba_cell #(.SIZE_BITS(SIZE_BITS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .data_in  (tap[i-1]),
            .data_out (tap[i])
         );
      end
   endgenerate

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      peak_in = peak_ff;
      if (load) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         peak_in = '0;
      end else if (run_ff) begin
         if (tap[HISTORY_COUNT-1] > peak_ff) begin
            peak_in = tap[HISTORY_COUNT-1];
         end
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         peak_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         peak_ff <= peak_in;
      end
   end

   assign done = done_ff;
   assign peak = peak_ff;

endmodule

// ----- hdl/frame_bump_allocator_core.sv -----
// Top level of the frame bump allocator with rotating heaps
// Allocate: result in the cycle after the beat is taken; a new allocate each cycle while idle.
// Frame end: busy until one full rotation of the history ring has found the
// peak; the result is registered after the ring reports done.
// Results carry no back-pressure: rsp_strobe marks each for one cycle.
// Synchronous reset clears the counter, heap sizes, heap index and history ring.
`timescale 1ns / 1ps
`include "frame_bump_allocator_core_assert.svh"
module frame_bump_allocator_core #(
   parameter int HEAP_COUNT    = 4,
   parameter int HISTORY_COUNT = 16,
   parameter int SIZE_BITS     = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  fba_pkg::command_type              req_command,
   input  logic [fba_pkg::FIELD_BITS-1:0]    req_request_bytes,
   output logic                              rsp_strobe,
   output logic                              rsp_placed,
   output logic                              rsp_fallback,
   output logic [fba_pkg::FIELD_BITS-1:0]    rsp_offset,
   output logic [fba_pkg::INDEX_BITS-1:0]    rsp_heap_index,
   output logic [fba_pkg::FIELD_BITS-1:0]    rsp_heap_bytes,
   output logic                              rsp_resize_needed
);

   import fba_pkg::*;

   localparam int HEAP_W = (HEAP_COUNT > 1) ? $clog2(HEAP_COUNT) : 1;
   localparam int WIDE   = (SIZE_BITS > FIELD_BITS) ? SIZE_BITS : FIELD_BITS;
   localparam int IDX_WIDE = (HEAP_W > INDEX_BITS) ? HEAP_W : INDEX_BITS;
   localparam logic [HEAP_W-1:0]    LAST_HEAP = HEAP_W'(HEAP_COUNT - 1);
   localparam logic [SIZE_BITS-1:0] SIZE_MAX  = {SIZE_BITS{1'b1}};

   typedef enum logic {
      S_IDLE,
      S_RUN
   } state_type;

   state_type            state_ff, state_in;
   logic [SIZE_BITS-1:0] used_ff, used_in;
   logic [HEAP_W-1:0]    heap_ff, heap_in;
   logic [SIZE_BITS-1:0] heap_size_ff [HEAP_COUNT];
   logic                 size_we;

   logic                      strobe_ff, strobe_in;
   logic                      placed_ff, placed_in;
   logic                      fallback_ff, fallback_in;
   logic [FIELD_BITS-1:0]     offset_ff, offset_in;
   logic [INDEX_BITS-1:0]     index_ff, index_in;
   logic [FIELD_BITS-1:0]     bytes_ff, bytes_in;
   logic                      resize_ff, resize_in;

   logic                 accept;
   logic [HEAP_W-1:0]    next_heap;
   logic [HEAP_W-1:0]    rd_idx;
   logic [SIZE_BITS-1:0] rd_size;
   logic [WIDE-1:0]      req_wide;
   logic [SIZE_BITS-1:0] req_sat;
   logic [SIZE_BITS:0]   sum;
   logic                 fits;
   logic [WIDE-1:0]      used_wide;
   logic [WIDE-1:0]      size_wide;
   logic [WIDE-1:0]      peak_wide;
   logic [IDX_WIDE-1:0]  idx_wide;

   logic                 ring_load;
   logic                 ring_done;
   logic [SIZE_BITS-1:0] ring_peak;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign ring_load = accept && (req_command == CMD_FRAME_END);

   assign next_heap = (heap_ff == LAST_HEAP) ? '0 : heap_ff + HEAP_W'(1);
   assign rd_idx    = (state_ff == S_RUN) ? next_heap : heap_ff;
   assign rd_size   = heap_size_ff[rd_idx];

   assign req_wide = WIDE'(req_request_bytes);
   assign req_sat  = (req_wide > WIDE'(SIZE_MAX)) ? SIZE_MAX : req_wide[SIZE_BITS-1:0];
   assign sum      = {1'b0, used_ff} + {1'b0, req_sat};
   assign fits     = (sum <= {1'b0, rd_size});

   assign used_wide = WIDE'(used_ff);
   assign size_wide = WIDE'(rd_size);
   assign peak_wide = WIDE'(ring_peak);

   fba_ring #(
      .HISTORY_COUNT (HISTORY_COUNT),
      .SIZE_BITS     (SIZE_BITS)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .load       (ring_load),
      .load_value (used_ff),
      .done       (ring_done),
      .peak       (ring_peak)
   );

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      heap_in     = heap_ff;
      size_we     = 1'b0;
      strobe_in   = 1'b0;
      placed_in   = placed_ff;
      fallback_in = fallback_ff;
      offset_in   = offset_ff;
      index_in    = index_ff;
      bytes_in    = bytes_ff;
      resize_in   = resize_ff;
      idx_wide    = IDX_WIDE'(heap_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_ALLOC) begin
                  strobe_in   = 1'b1;
                  placed_in   = fits;
                  fallback_in = !fits;
                  offset_in   = fits ? used_wide[FIELD_BITS-1:0] : '0;
                  index_in    = idx_wide[INDEX_BITS-1:0];
                  bytes_in    = size_wide[FIELD_BITS-1:0];
                  resize_in   = 1'b0;
                  used_in     = sum[SIZE_BITS] ? SIZE_MAX : sum[SIZE_BITS-1:0];
               end else begin
                  used_in  = '0;
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (ring_done) begin
               idx_wide    = IDX_WIDE'(next_heap);
               strobe_in   = 1'b1;
               placed_in   = 1'b0;
               fallback_in = 1'b0;
               offset_in   = '0;
               index_in    = idx_wide[INDEX_BITS-1:0];
               bytes_in    = peak_wide[FIELD_BITS-1:0];
               resize_in   = (rd_size != ring_peak);
               size_we     = 1'b1;
               heap_in     = next_heap;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         used_ff   <= '0;
         heap_ff   <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < HEAP_COUNT; i++) begin
            heap_size_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         heap_ff   <= heap_in;
         strobe_ff <= strobe_in;
         if (size_we) begin
            heap_size_ff[rd_idx] <= ring_peak;
         end
      end
      placed_ff   <= placed_in;
      fallback_ff <= fallback_in;
      offset_ff   <= offset_in;
      index_ff    <= index_in;
      bytes_ff    <= bytes_in;
      resize_ff   <= resize_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_placed        = placed_ff;
   assign rsp_fallback      = fallback_ff;
   assign rsp_offset        = offset_ff;
   assign rsp_heap_index    = index_ff;
   assign rsp_heap_bytes    = bytes_ff;
   assign rsp_resize_needed = resize_ff;

   `FBA_ASSERT_SAME(a_place_excl, clock, reset, rsp_strobe && rsp_placed, !rsp_fallback)
   `FBA_ASSERT_NEXT(a_frame_busy, clock, reset, ring_load, busy && !rsp_strobe)
   `FBA_ASSERT_SAME(a_done_in_run, clock, reset, ring_done, state_ff == S_RUN)
   `FBA_ASSERT_SAME(a_resize_frame, clock, reset,
                    rsp_strobe && rsp_resize_needed, !rsp_placed && !rsp_fallback)
   `FBA_ASSERT_NEXT(a_frame_clear, clock, reset, ring_load, used_ff == '0)

endmodule
